// ----- rtl/cpz_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package cpz_pkg;

  // character grid
  localparam int SCREEN_COLUMNS = 88;
  localparam int SCREEN_ROWS    = 44;
  localparam int PIXEL_COUNT    = SCREEN_COLUMNS * SCREEN_ROWS;
  localparam int IDX_W          = $clog2(PIXEL_COUNT);

  localparam logic [7:0] BLANK_GLYPH = 8'd32;

  // result status codes
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_HIDDEN    = 2'd1;
  localparam logic [1:0] STAT_OFFSCREEN = 2'd2;
  localparam logic [1:0] STAT_BEHIND    = 2'd3;

  // item kinds passed from front to back
  localparam logic [1:0] KIND_IMM  = 2'd0;
  localparam logic [1:0] KIND_READ = 2'd1;
  localparam logic [1:0] KIND_PLOT = 2'd2;

  // input function codes
  localparam logic FUNC_PLOT = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // register indexes
  localparam logic [2:0] REG_ROW_U  = 3'd0;
  localparam logic [2:0] REG_ROW_V  = 3'd1;
  localparam logic [2:0] REG_ROW_W  = 3'd2;
  localparam logic [2:0] REG_HALF_W = 3'd3;
  localparam logic [2:0] REG_CAMERA = 3'd4;
  localparam logic [2:0] REG_SCALE  = 3'd5;

  typedef struct packed {
    logic [47:0] row_u;
    logic [47:0] row_v;
    logic [47:0] row_w;
    logic [10:0] half_width;
    logic [9:0]  cam_dist;
    logic [9:0]  proj_scale;
  } cfg_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [7:0]        glyph;
    logic [1:0]        status;
    logic [IDX_W-1:0]  index;
    logic signed [12:0] px;
    logic signed [12:0] py;
    logic signed [12:0] pz;
  } desc_t;

  function automatic logic [7:0] face_glyph(input logic [2:0] f);
    logic [7:0] g;
    g = BLANK_GLYPH;
    unique case (f)
      3'd0: g = 8'h2E;
      3'd1: g = 8'h25;
      3'd2: g = 8'h2F;
      3'd3: g = 8'h3A;
      3'd4: g = 8'h2A;
      3'd5: g = 8'h21;
      default: g = BLANK_GLYPH;
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/cube_point_project_zbuffer_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Cube point projector with an 88x44 depth-tested character grid. After reset
// the pixel store is swept to blank at depth 0, one pixel a cycle, and no item
// is taken meanwhile (configuration writes are). Items are handled one at a
// time by the back-end sequencer behind a two-entry queue: a plot steps through
// the three rotation rows, the bit-serial inverse-depth divider (skipped when
// the depth saturates), then column, row, index, store read and write; a
// read-and-clear does only the store read and write, and an item rejected at
// the front goes straight to the result. The one write port of the pixel store
// carries both the depth-test writes and the clears.
module cube_point_project_zbuffer_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [47:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_func,
  input  wire logic [2:0]         in_face,
  input  wire logic signed [11:0] in_coord_s,
  input  wire logic signed [11:0] in_coord_t,
  input  wire logic [11:0]        in_read_index,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [7:0]              out_glyph,
  output logic [1:0]              out_status,
  output logic [11:0]             out_target_index
);
  import cpz_pkg::*;

  cfg_t  cfg_r;
  desc_t f_desc, q_head;
  logic  f_push, q_pop, q_empty, q_full, clearing;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.row_u      <= 48'd16384;
      cfg_r.row_v      <= 48'd1073741824;
      cfg_r.row_w      <= 48'd70368744177664;
      cfg_r.half_width <= 11'd240;
      cfg_r.cam_dist   <= 10'd175;
      cfg_r.proj_scale <= 10'd120;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROW_U:  cfg_r.row_u      <= cfg_data;
        REG_ROW_V:  cfg_r.row_v      <= cfg_data;
        REG_ROW_W:  cfg_r.row_w      <= cfg_data;
        REG_HALF_W: cfg_r.half_width <= cfg_data[10:0];
        REG_CAMERA: cfg_r.cam_dist   <= cfg_data[9:0];
        REG_SCALE:  cfg_r.proj_scale <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  cpz_front u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_func       (in_func),
    .in_face       (in_face),
    .in_coord_s    (in_coord_s),
    .in_coord_t    (in_coord_t),
    .in_read_index (in_read_index),
    .half_width    (cfg_r.half_width),
    .q_full        (q_full),
    .clearing      (clearing),
    .push          (f_push),
    .desc          (f_desc)
  );

  cpz_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_push),
    .push_desc (f_desc),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  cpz_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .head             (q_head),
    .q_empty          (q_empty),
    .pop              (q_pop),
    .clearing         (clearing),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_glyph        (out_glyph),
    .out_status       (out_status),
    .out_target_index (out_target_index)
  );
endmodule
`default_nettype wire

// ----- rtl/cpz_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cpz_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ----- rtl/cpz_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cpz_front (
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_func,
  input  wire logic [2:0]         in_face,
  input  wire logic signed [11:0] in_coord_s,
  input  wire logic signed [11:0] in_coord_t,
  input  wire logic [11:0]        in_read_index,
  input  wire logic [10:0]        half_width,
  input  wire logic               q_full,
  input  wire logic               clearing,
  output logic                    push,
  output cpz_pkg::desc_t          desc
);
  import cpz_pkg::*;

  logic signed [12:0] s13, t13, w13;
  logic               ri_ok;

  assign in_ready = !q_full && !clearing;
  assign push     = in_valid && in_ready;

  assign s13   = {in_coord_s[11], in_coord_s};
  assign t13   = {in_coord_t[11], in_coord_t};
  assign w13   = {2'b00, half_width};
  assign ri_ok = 32'(in_read_index) < 32'(PIXEL_COUNT);

  // classify the item and map a face point to the cube
  always_comb begin
    desc.kind   = KIND_PLOT;
    desc.glyph  = face_glyph(in_face);
    desc.status = STAT_OK;
    desc.index  = IDX_W'(in_read_index);
    desc.px     = s13;
    desc.py     = t13;
    desc.pz     = -w13;
    if (in_func == FUNC_READ) begin
      desc.kind = ri_ok ? KIND_READ : KIND_IMM;
      if (!ri_ok) begin
        desc.glyph  = BLANK_GLYPH;
        desc.status = STAT_OFFSCREEN;
        desc.index  = '0;
      end
    end else begin
      unique case (in_face)
        3'd0: begin desc.px = s13;  desc.py = t13;  desc.pz = -w13; end
        3'd1: begin desc.px = w13;  desc.py = t13;  desc.pz = s13;  end
        3'd2: begin desc.px = -w13; desc.py = t13;  desc.pz = s13;  end
        3'd3: begin desc.px = -s13; desc.py = t13;  desc.pz = w13;  end
        3'd4: begin desc.px = s13;  desc.py = -w13; desc.pz = -t13; end
        3'd5: begin desc.px = s13;  desc.py = w13;  desc.pz = t13;  end
        default: begin
          desc.kind   = KIND_IMM;
          desc.glyph  = BLANK_GLYPH;
          desc.status = STAT_OFFSCREEN;
          desc.index  = '0;
        end
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- rtl/cpz_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cpz_queue (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire cpz_pkg::desc_t push_desc,
  input  wire logic           pop,
  output cpz_pkg::desc_t      head,
  output logic                empty,
  output logic                full
);
  import cpz_pkg::*;

  desc_t      slot_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] count_r;

  assign head  = slot_r[rd_ptr_r];
  assign empty = (count_r == 2'd0);
  assign full  = (count_r == 2'd2);

  // two-entry ring
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_desc;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/cpz_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module cpz_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire cpz_pkg::cfg_t  cfg,
  input  wire cpz_pkg::desc_t head,
  input  wire logic           q_empty,
  output logic                pop,
  output logic                clearing,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic [7:0]          out_glyph,
  output logic [1:0]          out_status,
  output logic [11:0]         out_target_index
);
  import cpz_pkg::*;

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_ROT   = 4'd2;
  localparam logic [3:0] S_CHK   = 4'd3;
  localparam logic [3:0] S_DIV   = 4'd4;
  localparam logic [3:0] S_COL   = 4'd5;
  localparam logic [3:0] S_ROW   = 4'd6;
  localparam logic [3:0] S_IDX   = 4'd7;
  localparam logic [3:0] S_RD    = 4'd8;
  localparam logic [3:0] S_CMP   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0]          state_r, state_nxt;
  logic [IDX_W-1:0]    clr_cnt_r;
  logic [3:0]          cnt_r;
  desc_t               e_r;
  logic signed [30:0]  ru_r, rv_r;
  logic signed [31:0]  rz_r;
  logic [31:0]         rem_r;
  logic [15:0]         ooz_r;
  logic signed [18:0]  col_r, row_r;
  logic [IDX_W-1:0]    addr_r;
  logic [7:0]          res_glyph_r;
  logic [1:0]          res_status_r;
  logic [11:0]         res_index_r;
  logic                out_valid_r;
  logic [7:0]          out_glyph_r;
  logic [1:0]          out_status_r;
  logic [11:0]         out_index_r;

  logic [47:0]         row_sel;
  logic signed [30:0]  dot;
  logic [39:0]         num;
  logic                sat;
  logic [32:0]         rem2;
  logic signed [47:0]  prod, lin;
  logic signed [29:0]  idxv;
  logic                ram_we, ram_re;
  logic [IDX_W-1:0]    ram_waddr;
  logic [23:0]         ram_wdata, ram_rdata;

  // truncate a Q.30 value toward zero
  function automatic logic signed [18:0] trunc30(input logic signed [47:0] v);
    logic [47:0] mag;
    logic [18:0] q;
    mag = v[47] ? 48'(-v) : 48'(v);
    q   = 19'(mag >> 30);
    return v[47] ? -$signed(q) : $signed(q);
  endfunction

  assign clearing = (state_r == S_CLEAR);
  assign pop      = (state_r == S_IDLE) && !q_empty;

  // one rotation row per cycle
  always_comb begin
    unique case (cnt_r[1:0])
      2'd0: row_sel = cfg.row_u;
      2'd1: row_sel = cfg.row_v;
      default: row_sel = cfg.row_w;
    endcase
    dot = 31'($signed(row_sel[15:0]) * e_r.px) + 31'($signed(row_sel[31:16]) * e_r.py)
        + 31'($signed(row_sel[47:32]) * e_r.pz);
  end

  // inverse depth: saturation check and restoring division step
  assign num  = {cfg.proj_scale, 30'b0};
  assign sat  = {8'b0, num} >= {rz_r, 16'b0};
  assign rem2 = {rem_r, 1'b0};

  // projection products
  always_comb begin
    if (state_r == S_COL) begin
      prod = 48'($signed({1'b0, ooz_r}) * ru_r);
      lin  = $signed(48'(SCREEN_COLUMNS) << 29) + prod;
    end else begin
      prod = 48'($signed({1'b0, ooz_r}) * rv_r);
      lin  = $signed(48'(SCREEN_ROWS) << 29) - prod;
    end
  end

  assign idxv = 30'(row_r) * $signed(30'(SCREEN_COLUMNS)) + 30'(col_r);

  // memory port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr_r;
    ram_wdata = {16'd0, BLANK_GLYPH};
    if (state_r == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt_r;
    end else if (state_r == S_CMP) begin
      if (e_r.kind == KIND_READ) begin
        ram_we = 1'b1;
      end else if (ooz_r > ram_rdata[23:8]) begin
        ram_we    = 1'b1;
        ram_wdata = {ooz_r, e_r.glyph};
      end
    end
  end
  assign ram_re = (state_r == S_RD);

  cpz_ram #(.WIDTH(24), .DEPTH(PIXEL_COUNT)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (clr_cnt_r == IDX_W'(PIXEL_COUNT - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (!q_empty) begin
          unique case (head.kind)
            KIND_IMM:  state_nxt = S_DONE;
            KIND_READ: state_nxt = S_RD;
            default:   state_nxt = S_ROT;
          endcase
        end
      end
      S_ROT:  if (cnt_r == 4'd2) state_nxt = S_CHK;
      S_CHK: begin
        if (rz_r <= 0)  state_nxt = S_DONE;
        else if (sat)   state_nxt = S_COL;
        else            state_nxt = S_DIV;
      end
      S_DIV:  if (cnt_r == 4'd0) state_nxt = S_COL;
      S_COL:  state_nxt = S_ROW;
      S_ROW:  state_nxt = S_IDX;
      S_IDX: begin
        if (idxv < 0 || idxv >= 30'(PIXEL_COUNT)) state_nxt = S_DONE;
        else                                      state_nxt = S_RD;
      end
      S_RD:   state_nxt = S_CMP;
      S_CMP:  state_nxt = S_DONE;
      S_DONE: if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + IDX_W'(1);
      end
      if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        e_r          <= head;
        cnt_r        <= 4'd0;
        addr_r       <= head.index;
        res_glyph_r  <= head.glyph;
        res_status_r <= head.status;
        res_index_r  <= 12'(head.index);
      end
      S_ROT: begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'd0) ru_r <= dot;
        if (cnt_r == 4'd1) rv_r <= dot;
        if (cnt_r == 4'd2) rz_r <= 32'(dot) + $signed({4'b0, cfg.cam_dist, 18'b0});
      end
      S_CHK: begin
        cnt_r        <= 4'd15;
        ooz_r        <= 16'hFFFF;
        rem_r        <= 32'(num[39:16]);
        res_status_r <= STAT_BEHIND;
        res_index_r  <= '0;
      end
      S_DIV: begin
        cnt_r <= cnt_r - 4'd1;
        if (rem2 >= {1'b0, rz_r}) begin
          rem_r <= 32'(rem2 - {1'b0, rz_r});
          ooz_r <= {ooz_r[14:0], 1'b1};
        end else begin
          rem_r <= rem2[31:0];
          ooz_r <= {ooz_r[14:0], 1'b0};
        end
      end
      S_COL: col_r <= trunc30(lin);
      S_ROW: row_r <= trunc30(lin);
      S_IDX: begin
        addr_r       <= IDX_W'(idxv);
        res_status_r <= STAT_OFFSCREEN;
        if (idxv < 0 || idxv >= 30'(PIXEL_COUNT)) begin
          res_index_r <= '0;
        end else begin
          res_index_r <= 12'(idxv);
        end
      end
      S_CMP: begin
        if (e_r.kind == KIND_READ) begin
          res_glyph_r  <= ram_rdata[7:0];
          res_status_r <= STAT_OK;
        end else begin
          res_status_r <= (ooz_r > ram_rdata[23:8]) ? STAT_OK : STAT_HIDDEN;
        end
      end
      default: ;
    endcase
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_glyph_r  <= res_glyph_r;
      out_status_r <= res_status_r;
      out_index_r  <= res_index_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_glyph        = out_glyph_r;
  assign out_status       = out_status_r;
  assign out_target_index = out_index_r;

  // checks
  a_cmp_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CMP |-> $past(state_r) == S_RD)
    else $error("compare without read");
  a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_CLEAR || state_r == S_CMP))
    else $error("store written outside clear or compare");
  a_offscreen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == STAT_OFFSCREEN || out_status_r == STAT_BEHIND)
      |-> out_index_r == 12'd0)
    else $error("nonzero index on rejected point");
  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !pop)
    else $error("item taken during clear");
endmodule
`default_nettype wire

// ----- tb/cube_point_project_zbuffer_unit_tb.sv -----
`timescale 1ns / 1ps
module cube_point_project_zbuffer_unit_tb;
  import cpz_pkg::*;

  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 40;
  localparam int CENTER_ROW = SCREEN_ROWS / 2;
  localparam int CENTER_COL = SCREEN_COLUMNS / 2;

  typedef struct {
    bit        func;
    bit [2:0]  face;
    bit [11:0] s;
    bit [11:0] t;
    bit [11:0] read_index;
  } point_item_t;

  typedef struct {
    bit [7:0]  glyph;
    bit [1:0]  status;
    bit [11:0] index;
  } pixel_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = REG_ROW_U;
  logic [47:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_func = FUNC_PLOT;
  logic [2:0] in_face = '0;
  logic signed [11:0] in_coord_s = '0;
  logic signed [11:0] in_coord_t = '0;
  logic [11:0] in_read_index = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [7:0] out_glyph;
  logic [1:0] out_status;
  logic [11:0] out_target_index;

  // shadow of the block's registers and pixel store
  bit [47:0] row_u_q, row_v_q, row_w_q;
  bit [10:0] half_width_q;
  bit [9:0] cam_dist_q, proj_scale_q;
  bit [15:0] depth_mem [PIXEL_COUNT];
  bit [7:0] glyph_mem [PIXEL_COUNT];
  bit [7:0] face_chars [6] = '{8'h2E, 8'h25, 8'h2F, 8'h3A, 8'h2A, 8'h21};

  point_item_t pending_items[$];
  pixel_result_t expected_pixels[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int quiet_cycles = 0;

  cube_point_project_zbuffer_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_func(in_func), .in_face(in_face),
    .in_coord_s(in_coord_s), .in_coord_t(in_coord_t), .in_read_index(in_read_index),
    .out_valid(out_valid), .out_ready(out_ready), .out_glyph(out_glyph),
    .out_status(out_status), .out_target_index(out_target_index)
  );

  always #5 clk = ~clk;

  function automatic longint coef(bit [47:0] row, int k);
    bit [15:0] c;
    c = row[16*k +: 16];
    return longint'($signed(c));
  endfunction

  function automatic longint rotate(bit [47:0] row, longint x, longint y, longint z);
    return coef(row, 0) * x + coef(row, 1) * y + coef(row, 2) * z;
  endfunction

  // project one item through the shadow state and update it
  function automatic pixel_result_t project_point(point_item_t it);
    pixel_result_t r;
    longint s, t, hw, x, y, z, ru, rv, rz, ooz, col, row, idx;
    s = longint'($signed(it.s));
    t = longint'($signed(it.t));
    hw = longint'(half_width_q);
    r.glyph = BLANK_GLYPH;
    r.status = STAT_OFFSCREEN;
    r.index = '0;
    if (it.func == FUNC_READ) begin
      if (it.read_index < PIXEL_COUNT) begin
        r.glyph = glyph_mem[it.read_index];
        r.status = STAT_OK;
        r.index = it.read_index;
        glyph_mem[it.read_index] = BLANK_GLYPH;
        depth_mem[it.read_index] = '0;
      end
      return r;
    end
    if (it.face > 5) return r;
    r.glyph = face_chars[it.face];
    case (it.face)
      3'd0: begin x = s; y = t; z = -hw; end
      3'd1: begin x = hw; y = t; z = s; end
      3'd2: begin x = -hw; y = t; z = s; end
      3'd3: begin x = -s; y = t; z = hw; end
      3'd4: begin x = s; y = -hw; z = -t; end
      default: begin x = s; y = hw; z = t; end
    endcase
    ru = rotate(row_u_q, x, y, z);
    rv = rotate(row_v_q, x, y, z);
    rz = rotate(row_w_q, x, y, z) + (longint'(cam_dist_q) << 18);
    if (rz <= 0) begin
      r.status = STAT_BEHIND;
      return r;
    end
    ooz = (longint'(proj_scale_q) << 30) / rz;
    if (ooz > 65535) ooz = 65535;
    // signed division truncates toward zero
    col = ((longint'(SCREEN_COLUMNS) << 29) + ooz * ru) / 64'sd1073741824;
    row = ((longint'(SCREEN_ROWS) << 29) - ooz * rv) / 64'sd1073741824;
    idx = row * SCREEN_COLUMNS + col;
    if (idx < 0 || idx >= PIXEL_COUNT) return r;
    r.index = idx[11:0];
    if (ooz[15:0] > depth_mem[idx]) begin
      depth_mem[idx] = ooz[15:0];
      glyph_mem[idx] = r.glyph;
      r.status = STAT_OK;
    end else begin
      r.status = STAT_HIDDEN;
    end
    return r;
  endfunction

  // input driver
  always @(posedge clk) begin
    point_item_t cur, nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        cur.func = in_func;
        cur.face = in_face;
        cur.s = in_coord_s;
        cur.t = in_coord_t;
        cur.read_index = in_read_index;
        expected_pixels.push_back(project_point(cur));
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_items.pop_front();
          in_func <= nxt.func;
          in_face <= nxt.face;
          in_coord_s <= nxt.s;
          in_coord_t <= nxt.t;
          in_read_index <= nxt.read_index;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    pixel_result_t e;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: unexpected item glyph %0d status %0d index %0d", $time,
                   out_glyph, out_status, out_target_index);
          errors++;
        end else begin
          e = expected_pixels.pop_front();
          if (out_glyph !== e.glyph) begin
            $display("%0t: glyph expected %0d actual %0d", $time, e.glyph, out_glyph);
            errors++;
          end
          if (out_status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $time, e.status, out_status);
            errors++;
          end
          if (out_target_index !== e.index) begin
            $display("%0t: target_index expected %0d actual %0d", $time, e.index,
                     out_target_index);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog on handshake progress
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("cube_point_project_zbuffer_unit_tb NOT OK");
      $finish;
    end
  end

  // valid stays up across back-to-back writes; write_all drops it at the end
  task automatic write_reg(bit [2:0] idx, bit [47:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_ROW_U: row_u_q = val;
      REG_ROW_V: row_v_q = val;
      REG_ROW_W: row_w_q = val;
      REG_HALF_W: half_width_q = val[10:0];
      REG_CAMERA: cam_dist_q = val[9:0];
      REG_SCALE: proj_scale_q = val[9:0];
      default: ;
    endcase
  endtask

  task automatic write_all(bit [47:0] u, bit [47:0] v, bit [47:0] w,
                           bit [10:0] hw, bit [9:0] cam, bit [9:0] sc);
    write_reg(REG_ROW_U, u);
    write_reg(REG_ROW_V, v);
    write_reg(REG_ROW_W, w);
    write_reg(REG_HALF_W, hw);
    write_reg(REG_CAMERA, cam);
    write_reg(REG_SCALE, sc);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_item(bit func, bit [2:0] face, bit [11:0] s, bit [11:0] t,
                          bit [11:0] ri);
    point_item_t it;
    it.func = func;
    it.face = face;
    it.s = s;
    it.t = t;
    it.read_index = ri;
    pending_items.push_back(it);
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (pending_items.size() > 0 || in_valid || expected_pixels.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic bit [47:0] small_row();
    bit [47:0] r;
    for (int k = 0; k < 3; k++)
      r[16*k +: 16] = 16'($signed($urandom_range(32768)) - 16384);
    return r;
  endfunction

  // mostly on-cube plots, some raw noise, reads near the drawn area
  task automatic add_random_items(int n);
    int hw, pick, r, c;
    hw = (half_width_q > 2047) ? 2047 : half_width_q;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        add_item(FUNC_PLOT, 3'($urandom_range(5)),
                 12'($signed($urandom_range(2 * hw)) - hw),
                 12'($signed($urandom_range(2 * hw)) - hw), 12'($urandom));
      end else if (pick < 80) begin
        add_item(1'($urandom), 3'($urandom), 12'($urandom), 12'($urandom),
                 12'($urandom));
      end else begin
        r = $urandom_range(CENTER_ROW + 12, CENTER_ROW - 12);
        c = $urandom_range(CENTER_COL + 24, CENTER_COL - 24);
        add_item(FUNC_READ, 3'($urandom), 12'($urandom), 12'($urandom),
                 ($urandom_range(3) == 0) ? 12'($urandom) : 12'(r * SCREEN_COLUMNS + c));
      end
    end
  endtask

  initial begin
    row_u_q = 48'd16384;
    row_v_q = 48'd1073741824;
    row_w_q = 48'd70368744177664;
    half_width_q = 11'd240;
    cam_dist_q = 10'd175;
    proj_scale_q = 10'd120;
    for (int i = 0; i < PIXEL_COUNT; i++) begin
      depth_mem[i] = '0;
      glyph_mem[i] = BLANK_GLYPH;
    end
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: every face, coordinate extremes, reads at grid edges
    send_idle_pct = 11;
    recv_stall_pct = 67;
    write_all(48'd16384, 48'd1073741824, 48'd70368744177664, 11'd240, 10'd175, 10'd120);
    for (int f = 0; f < 8; f++)
      add_item(FUNC_PLOT, 3'(f), 12'sd0, 12'sd0, 12'd0);
    add_item(FUNC_PLOT, 3'd3, 12'h7FF, 12'h800, 12'hFFF);
    add_item(FUNC_PLOT, 3'd5, 12'h800, 12'h7FF, 12'd0);
    add_item(FUNC_PLOT, 3'd3, 12'sd0, 12'sd0, 12'd0);
    add_item(FUNC_PLOT, 3'd0, 12'sd0, 12'sd0, 12'd0);
    add_item(FUNC_READ, 3'd0, 12'd0, 12'd0, 12'd1980);
    add_item(FUNC_READ, 3'd0, 12'd0, 12'd0, 12'd0);
    add_item(FUNC_READ, 3'd7, 12'hFFF, 12'hFFF, 12'd3871);
    add_item(FUNC_READ, 3'd0, 12'd0, 12'd0, 12'd3872);
    add_item(FUNC_READ, 3'd0, 12'd0, 12'd0, 12'hFFF);
    wait_idle();

    // camera at zero puts the near face behind; zero scale never beats depth
    write_all(48'd16384, 48'd1073741824, 48'd70368744177664, 11'd240, 10'd0, 10'd0);
    add_item(FUNC_PLOT, 3'd0, 12'sd0, 12'sd0, 12'd0);
    add_item(FUNC_PLOT, 3'd3, 12'sd0, 12'sd0, 12'd0);
    add_item(FUNC_PLOT, 3'd1, 12'sd0, 12'sd0, 12'd0);
    add_item(FUNC_PLOT, 3'd4, 12'sd100, 12'sd100, 12'd0);
    wait_idle();

    // random phases across register settings and idling patterns
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = (p == 0) ? 11 : (p == 1) ? 67 : 0;
      recv_stall_pct = (p == 0) ? 67 : (p == 1) ? 11 : 0;
      for (int k = 0; k < 2; k++) begin
        case (p * 2 + k)
          0: write_all(48'd16384, 48'd1073741824, 48'd70368744177664,
                       11'd240, 10'd175, 10'd120);
          1: write_all(small_row(), small_row(), small_row(),
                       11'($urandom_range(400)), 10'($urandom_range(300, 30)),
                       10'($urandom_range(1023)));
          2: write_all(48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 48'h8000_8000_8000,
                       11'd2047, 10'd1023, 10'd1023);
          3: write_all({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                       11'($urandom), 10'($urandom), 10'($urandom));
          4: write_all(48'd0, 48'd0, 48'd0, 11'd0, 10'd1, 10'd1);
          default: write_all(small_row(), small_row(), small_row(),
                             11'($urandom_range(300)), 10'($urandom_range(200, 20)),
                             10'($urandom_range(1023, 500)));
        endcase
        add_random_items(65);
        wait_idle();
      end
    end

    if (errors == 0)
      $display("cube_point_project_zbuffer_unit_tb OK");
    else
      $display("cube_point_project_zbuffer_unit_tb NOT OK");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/cpz_pkg.sv
rtl/cpz_ram.sv
rtl/cpz_front.sv
rtl/cpz_queue.sv
rtl/cpz_back.sv
rtl/cube_point_project_zbuffer_unit.sv
tb/cube_point_project_zbuffer_unit_tb.sv
